### hdl/mweep_pkg.sv
// Shared constants and control types for the Microwire EEPROM slave core.
package mweep_pkg;

   // Pin snapshot layout
   localparam int PIN_W   = 8;
   localparam int PIN_SEL = 7;
   localparam int PIN_CLK = 6;
   localparam int PIN_DIN = 1;
   localparam int RSP_W   = 8;

   // Datapath widths
   localparam int WORD_W    = 16;
   localparam int ADDR_W    = 8;
   localparam int RAW_IDX_W = 7;
   localparam int CNT_W     = 5;
   localparam int PHASE_W   = 3;
   localparam int OPC_W     = 2;

   localparam logic [WORD_W-1:0] ERASED_WORD = 16'hFFFF;

   // Bit counts that close each field
   localparam logic [CNT_W-1:0] OPC_BITS  = 5'd2;
   localparam logic [CNT_W-1:0] ADDR_BITS = 5'd8;
   localparam logic [CNT_W-1:0] DATA_BITS = 5'd16;
   localparam logic [CNT_W-1:0] DUMMY_BITS = 5'd1;

   // Protocol phases
   localparam logic [PHASE_W-1:0] PH_WAIT    = 3'd0;
   localparam logic [PHASE_W-1:0] PH_OPCODE  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_ADDRESS = 3'd2;
   localparam logic [PHASE_W-1:0] PH_DATA    = 3'd3;
   localparam logic [PHASE_W-1:0] PH_READING = 3'd4;
   localparam logic [PHASE_W-1:0] PH_PENDING = 3'd5;

   // Opcodes
   localparam logic [OPC_W-1:0] OPC_EXT   = 2'd0;
   localparam logic [OPC_W-1:0] OPC_WRITE = 2'd1;
   localparam logic [OPC_W-1:0] OPC_READ  = 2'd2;
   localparam logic [OPC_W-1:0] OPC_ERASE = 2'd3;

   // Extended opcodes, from the top two address bits
   localparam logic [1:0] EXT_WDS  = 2'd0;
   localparam logic [1:0] EXT_WRAL = 2'd1;
   localparam logic [1:0] EXT_ERAL = 2'd2;
   localparam logic [1:0] EXT_WEN  = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic reduce;
      logic update;
      logic push;
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic idx_ok;
   } ctrl_status_type;

endpackage

### hdl/mweep_ctrl.sv
// Sequencer that steps each pin request through index reduction, update and output.
module mweep_ctrl
   import mweep_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_REDUCE = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;
   localparam logic [1:0] ST_PUSH   = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Decode commands from the current state
   always_comb begin
      cmd.load   = req_tvalid && (state_ff == ST_IDLE);
      cmd.reduce = (state_ff == ST_REDUCE) && !status.idx_ok;
      cmd.update = (state_ff == ST_UPDATE);
      cmd.push   = (state_ff == ST_PUSH) && out_free;
   end

   // Advance the sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (status.idx_ok) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result valid until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hdl/mweep_dp.sv
// Datapath: protocol registers, word store with valid bits and the result register.
module mweep_dp
   import mweep_pkg::*;
#(
   parameter int WORD_COUNT = 128
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic [PIN_W-1:0] pins,
   input  ctrl_cmd_type     cmd,
   output ctrl_status_type  status,
   output logic             rsp_bit
);

   localparam int IDX_W = $clog2(WORD_COUNT);
   localparam logic [RAW_IDX_W:0] COUNT_EXT = (RAW_IDX_W + 1)'(WORD_COUNT);

   // Latched request pins
   logic sel_ff, clk_ff, din_ff;

   // Protocol state
   logic               prev_sel_ff, prev_sel_in;
   logic               prev_clk_ff, prev_clk_in;
   logic               idle_ff, idle_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [WORD_W-1:0]  shift_ff, shift_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [OPC_W-1:0]   opc_ff, opc_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic               wen_ff, wen_in;
   logic               dout_ff, dout_in;

   // Store: words, per-word valid bits, value of words not written since last fill
   logic [WORD_W-1:0]     word_mem_ff [WORD_COUNT];
   logic [WORD_COUNT-1:0] valid_ff;
   logic [WORD_W-1:0]     base_ff;
   logic [RAW_IDX_W-1:0]  idx_ff;
   logic [WORD_W-1:0]     rd_word_ff;
   logic                  rd_vld_ff;
   logic                  rsp_bit_ff;

   logic              commit, fill;
   logic [WORD_W-1:0] fill_val;
   logic [WORD_W-1:0] mem_word;

   assign status.idx_ok = ({1'b0, idx_ff} < COUNT_EXT);
   assign mem_word      = rd_vld_ff ? rd_word_ff : base_ff;
   assign rsp_bit       = rsp_bit_ff;

   // Apply one pin snapshot: select edge, then rising clock, then falling clock
   always_comb begin
      prev_sel_in = sel_ff;
      prev_clk_in = clk_ff;
      idle_in     = idle_ff;
      phase_in    = phase_ff;
      shift_in    = shift_ff;
      count_in    = count_ff;
      opc_in      = opc_ff;
      addr_in     = addr_ff;
      wen_in      = wen_ff;
      dout_in     = dout_ff;
      commit      = 1'b0;
      fill        = 1'b0;
      fill_val    = ERASED_WORD;

      // Select rising: commit a pending write or arm for a start bit
      if (!prev_sel_ff && sel_ff) begin
         if (phase_ff == PH_PENDING) begin
            commit  = wen_ff;
            phase_in = PH_WAIT;
            dout_in = 1'b1;
         end else begin
            idle_in  = 1'b1;
            phase_in = PH_WAIT;
         end
      end

      // Rising clock: shift in start, opcode, address and data
      if (!prev_clk_ff && clk_ff) begin
         if (idle_in && din_ff) begin
            idle_in  = 1'b0;
            phase_in = PH_OPCODE;
         end else begin
            case (phase_in)
               PH_OPCODE: begin
                  shift_in = {shift_in[WORD_W-2:0], din_ff};
                  count_in = count_in + 1'b1;
                  if (count_in == OPC_BITS) begin
                     opc_in   = shift_in[OPC_W-1:0];
                     count_in = '0;
                     phase_in = PH_ADDRESS;
                  end
               end
               PH_ADDRESS: begin
                  shift_in = {shift_in[WORD_W-2:0], din_ff};
                  count_in = count_in + 1'b1;
                  if (count_in == ADDR_BITS) begin
                     addr_in  = shift_in[ADDR_W-1:0];
                     count_in = '0;
                     phase_in = PH_DATA;
                     if (opc_in == OPC_EXT) begin
                        if (addr_in[7:6] == EXT_WDS) begin
                           wen_in   = 1'b0;
                           phase_in = PH_WAIT;
                        end else if (addr_in[7:6] == EXT_WEN) begin
                           wen_in   = 1'b1;
                           phase_in = PH_WAIT;
                        end
                     end
                  end
               end
               PH_DATA: begin
                  shift_in = {shift_in[WORD_W-2:0], din_ff};
                  count_in = count_in + 1'b1;
                  case (opc_in)
                     OPC_EXT: begin
                        if (count_in == DATA_BITS) begin
                           case (addr_in[7:6])
                              EXT_WDS: begin
                                 wen_in   = 1'b0;
                                 phase_in = PH_WAIT;
                              end
                              EXT_WRAL: begin
                                 fill     = wen_in;
                                 fill_val = shift_in;
                                 phase_in = PH_PENDING;
                              end
                              EXT_ERAL: begin
                                 fill     = wen_in;
                                 phase_in = PH_PENDING;
                              end
                              default: begin
                                 wen_in   = 1'b1;
                                 phase_in = PH_WAIT;
                              end
                           endcase
                           count_in = '0;
                        end
                     end
                     OPC_WRITE: begin
                        if (count_in == DATA_BITS) begin
                           count_in = '0;
                           phase_in = PH_PENDING;
                           dout_in  = 1'b0;
                        end
                     end
                     OPC_READ: begin
                        if (count_in == DUMMY_BITS) begin
                           shift_in = mem_word;
                           phase_in = PH_READING;
                           count_in = '0;
                        end
                     end
                     default: begin
                        if (count_in == DATA_BITS) begin
                           count_in = '0;
                           shift_in = ERASED_WORD;
                           phase_in = PH_PENDING;
                           dout_in  = 1'b0;
                        end
                     end
                  endcase
               end
               default: begin
               end
            endcase
         end
      end

      // Falling clock while reading: shift out MSB first
      if (prev_clk_ff && !clk_ff && (phase_in == PH_READING)) begin
         dout_in  = shift_in[WORD_W-1];
         shift_in = {shift_in[WORD_W-2:0], 1'b0};
         count_in = count_in + 1'b1;
         if (count_in == DATA_BITS) begin
            count_in = '0;
            phase_in = PH_WAIT;
         end
      end
   end

   // Control state and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_sel_ff <= 1'b0;
         prev_clk_ff <= 1'b0;
         idle_ff     <= 1'b0;
         phase_ff    <= PH_WAIT;
         shift_ff    <= '0;
         count_ff    <= '0;
         opc_ff      <= OPC_EXT;
         addr_ff     <= '0;
         wen_ff      <= 1'b0;
         dout_ff     <= 1'b0;
         valid_ff    <= '0;
         base_ff     <= ERASED_WORD;
      end else if (cmd.update) begin
         prev_sel_ff <= prev_sel_in;
         prev_clk_ff <= prev_clk_in;
         idle_ff     <= idle_in;
         phase_ff    <= phase_in;
         shift_ff    <= shift_in;
         count_ff    <= count_in;
         opc_ff      <= opc_in;
         addr_ff     <= addr_in;
         wen_ff      <= wen_in;
         dout_ff     <= dout_in;
         if (fill) begin
            valid_ff <= '0;
            base_ff  <= fill_val;
         end else if (commit) begin
            valid_ff[idx_ff[IDX_W-1:0]] <= 1'b1;
         end
      end
   end

   // Latch pins, reduce the word index modulo the store depth and load the result bit
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sel_ff <= pins[PIN_SEL];
         clk_ff <= pins[PIN_CLK];
         din_ff <= pins[PIN_DIN];
         idx_ff <= addr_ff[RAW_IDX_W-1:0];
      end else if (cmd.reduce) begin
         idx_ff <= idx_ff - COUNT_EXT[RAW_IDX_W-1:0];
      end
      if (cmd.push) begin
         rsp_bit_ff <= dout_ff;
      end
   end

   // Word store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.update && commit) begin
         word_mem_ff[idx_ff[IDX_W-1:0]] <= shift_ff;
      end
      rd_word_ff <= word_mem_ff[idx_ff[IDX_W-1:0]];
      rd_vld_ff  <= valid_ff[idx_ff[IDX_W-1:0]];
   end

endmodule

### hdl/microwire_eeprom_slave_core.sv
// Top level of the Microwire serial EEPROM slave: sequencer plus datapath.
// Each pin request steps through accept, index check, update and result load; the index
// check subtracts WORD_COUNT and repeats until the word index is below WORD_COUNT.
// The sequencer's four states take one request at a time; the result load waits for a free
// output register, but the next request is taken while a result still waits in it.
// Reset clears all control state and the per-word valid bits, so the store reads as
// erased at once; no clearing pass. Write-all and erase-all also finish in one update.
module microwire_eeprom_slave_core
   import mweep_pkg::*;
#(
   parameter int WORD_COUNT = 128
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [PIN_W-1:0] req_tdata,   // [7:0] pin_levels
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // [0] data_out, [7:1] zero
);

   ctrl_cmd_type    ctrl_cmd;
   ctrl_status_type ctrl_status;
   logic            rsp_bit;

   mweep_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (ctrl_status),
      .cmd        (ctrl_cmd)
   );

   mweep_dp #(
      .WORD_COUNT (WORD_COUNT)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .pins    (req_tdata),
      .cmd     (ctrl_cmd),
      .status  (ctrl_status),
      .rsp_bit (rsp_bit)
   );

   assign rsp_tdata = {{(RSP_W-1){1'b0}}, rsp_bit};

   // An accepted request blocks the input for the next cycle
   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted back to back");

   // The update step never overlaps request acceptance
   a_update_busy: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.update |-> !req_tready)
      else $error("update while accepting a request");

   // A result appears only after a result load
   a_rsp_from_push: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(ctrl_cmd.push))
      else $error("result valid without a load");

   // No request is loaded in the cycle right after an update
   a_push_after_update: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.update |=> !ctrl_cmd.load)
      else $error("request loaded right after update");

endmodule

### tb/mweep_checker.sv
// Checker for the Microwire EEPROM slave: predicts data out per pin request and compares.
module mweep_checker
   import mweep_pkg::*;
#(
   parameter int WORD_COUNT = 128
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [PIN_W-1:0] req_tdata,   // [7:0] pin_levels
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,   // [0] data_out, [7:1] zero
   output int               pending,
   output int               fail_count
);

   // Predicted device state
   logic                 sel_q;
   logic                 clk_q;
   logic                 idle_q;
   logic                 wen_q;
   logic                 dout_q;
   logic [PHASE_W-1:0]   phase_q;
   logic [WORD_W-1:0]    shift_q;
   logic [CNT_W-1:0]     count_q;
   logic [OPC_W-1:0]     opc_q;
   logic [ADDR_W-1:0]    addr_q;
   logic [WORD_W-1:0]    store_q [WORD_COUNT];

   // Expected data out bytes, oldest first
   logic [RSP_W-1:0]     dout_fifo [$];
   int                   errors = 0;

   assign fail_count = errors;

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
   endtask

   function automatic void fill_store(input logic [WORD_W-1:0] value);
      for (int i = 0; i < WORD_COUNT; i++) store_q[i] = value;
   endfunction

   function automatic int word_slot();
      return int'(addr_q[RAW_IDX_W-1:0]) % WORD_COUNT;
   endfunction

   function automatic void shift_bit(input logic din);
      shift_q = {shift_q[WORD_W-2:0], din};
      count_q = count_q + 1'b1;
   endfunction

   // Apply one pin snapshot: select edge, then rising clock, then falling clock
   function automatic logic predict_data_out(input logic [PIN_W-1:0] pins);
      logic sel;
      logic clk;
      logic din;
      logic sel_rise;
      logic clk_rise;
      logic clk_fall;
      sel      = pins[PIN_SEL];
      clk      = pins[PIN_CLK];
      din      = pins[PIN_DIN];
      sel_rise = !sel_q && sel;
      clk_rise = !clk_q && clk;
      clk_fall = clk_q && !clk;
      sel_q    = sel;
      clk_q    = clk;

      // Commit a pending write, or arm for a start bit
      if (sel_rise) begin
         if (phase_q == PH_PENDING) begin
            if (wen_q) store_q[word_slot()] = shift_q;
            dout_q = 1'b1;
         end else begin
            idle_q = 1'b1;
         end
         phase_q = PH_WAIT;
      end

      // Take the start bit, or shift into the current field
      if (clk_rise) begin
         if (idle_q && din) begin
            idle_q  = 1'b0;
            phase_q = PH_OPCODE;
         end else begin
            case (phase_q)
               PH_OPCODE: begin
                  shift_bit(din);
                  if (count_q == OPC_BITS) begin
                     opc_q   = shift_q[OPC_W-1:0];
                     count_q = '0;
                     phase_q = PH_ADDRESS;
                  end
               end
               PH_ADDRESS: begin
                  shift_bit(din);
                  if (count_q == ADDR_BITS) begin
                     addr_q  = shift_q[ADDR_W-1:0];
                     count_q = '0;
                     phase_q = PH_DATA;
                     // enable and disable finish with the address
                     if (opc_q == OPC_EXT) begin
                        if (addr_q[ADDR_W-1 -: 2] == EXT_WDS) begin
                           wen_q   = 1'b0;
                           phase_q = PH_WAIT;
                        end else if (addr_q[ADDR_W-1 -: 2] == EXT_WEN) begin
                           wen_q   = 1'b1;
                           phase_q = PH_WAIT;
                        end
                     end
                  end
               end
               PH_DATA: begin
                  shift_bit(din);
                  case (opc_q)
                     OPC_EXT: begin
                        if (count_q == DATA_BITS) begin
                           case (addr_q[ADDR_W-1 -: 2])
                              EXT_WDS: begin
                                 wen_q   = 1'b0;
                                 phase_q = PH_WAIT;
                              end
                              EXT_WRAL: begin
                                 if (wen_q) fill_store(shift_q);
                                 phase_q = PH_PENDING;
                              end
                              EXT_ERAL: begin
                                 if (wen_q) fill_store(ERASED_WORD);
                                 phase_q = PH_PENDING;
                              end
                              default: begin
                                 wen_q   = 1'b1;
                                 phase_q = PH_WAIT;
                              end
                           endcase
                           count_q = '0;
                        end
                     end
                     OPC_WRITE: begin
                        if (count_q == DATA_BITS) begin
                           count_q = '0;
                           phase_q = PH_PENDING;
                           dout_q  = 1'b0;
                        end
                     end
                     OPC_READ: begin
                        if (count_q == DUMMY_BITS) begin
                           shift_q = store_q[word_slot()];
                           phase_q = PH_READING;
                           count_q = '0;
                        end
                     end
                     default: begin
                        if (count_q == DATA_BITS) begin
                           count_q = '0;
                           shift_q = ERASED_WORD;
                           phase_q = PH_PENDING;
                           dout_q  = 1'b0;
                        end
                     end
                  endcase
               end
               default: ;
            endcase
         end
      end

      // Shift read data out, MSB first
      if (clk_fall && phase_q == PH_READING) begin
         dout_q  = shift_q[WORD_W-1];
         shift_q = shift_q << 1;
         count_q = count_q + 1'b1;
         if (count_q == DATA_BITS) begin
            count_q = '0;
            phase_q = PH_WAIT;
         end
      end
      return dout_q;
   endfunction

   // Check responses against the oldest expectation, then predict new requests
   always @(posedge clock) begin
      logic [RSP_W-1:0] want;
      if (reset) begin
         sel_q   = 1'b0;
         clk_q   = 1'b0;
         idle_q  = 1'b0;
         wen_q   = 1'b0;
         dout_q  = 1'b0;
         phase_q = PH_WAIT;
         shift_q = '0;
         count_q = '0;
         opc_q   = OPC_EXT;
         addr_q  = '0;
         fill_store(ERASED_WORD);
         dout_fifo.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (dout_fifo.size() == 0) begin
               report_mismatch($sformatf("response 0x%0h with no request outstanding",
                                         rsp_tdata));
            end else begin
               want = dout_fifo.pop_front();
               if (rsp_tdata !== want)
                  report_mismatch($sformatf("data_out: got 0x%0h, expected 0x%0h",
                                            rsp_tdata, want));
            end
         end
         if (req_tvalid && req_tready)
            dout_fifo.insert(dout_fifo.size(), RSP_W'(predict_data_out(req_tdata)));
      end
      pending <= dout_fifo.size();
   end

endmodule

### tb/tb_microwire_eeprom_slave_core.sv
// Testbench top for the Microwire EEPROM slave core: pin stimulus, flow control and verdict.
module tb_microwire_eeprom_slave_core;
   import mweep_pkg::*;

   localparam int WORD_COUNT   = 128;
   localparam int RANDOM_ITEMS = 560;
   localparam int IDLE_PCT     = 13;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [PIN_W-1:0] req_tdata  = '0;   // [7:0] pin_levels
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;         // [0] data_out, [7:1] zero
   int               pending;
   int               fail_count;
   int               pins_sent = 0;
   bit               gaps_on   = 1'b1;
   logic [ADDR_W-1:0] addr_pool [4] = '{8'h00, 8'h7F, 8'h80, 8'h35};

   microwire_eeprom_slave_core #(
      .WORD_COUNT (WORD_COUNT)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   mweep_checker #(
      .WORD_COUNT (WORD_COUNT)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .pending    (pending),
      .fail_count (fail_count)
   );

   always #6 clock = ~clock;

   // Stall the response side at random
   always @(posedge clock) begin
      rsp_tready <= reset ? 1'b0 : (!gaps_on || $urandom_range(99) >= IDLE_PCT);
   end

   // Build a pin snapshot with the ignored bits randomized
   function automatic logic [PIN_W-1:0] pin_snapshot(input logic sel, input logic clk,
                                                     input logic din);
      logic [PIN_W-1:0] v;
      v          = PIN_W'($urandom);
      v[PIN_SEL] = sel;
      v[PIN_CLK] = clk;
      v[PIN_DIN] = din;
      return v;
   endfunction

   // Present one pin request and hold it until accepted
   task automatic send_pins(input logic [PIN_W-1:0] pins);
      while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pins;
      do @(posedge clock); while (!req_tready);
      pins_sent++;
   endtask

   // Clock one command in; cut >= 0 aborts after that many clocked bits
   task automatic issue_command(input logic [OPC_W-1:0] opc, input logic [ADDR_W-1:0] addr,
                                input logic [WORD_W-1:0] data, input int cut);
      logic stream [$];
      int   lead;
      lead = $urandom_range(2);
      // leading zeros ahead of the start bit are ignored
      repeat (lead) stream.insert(stream.size(), 1'b0);
      stream.insert(stream.size(), 1'b1);
      for (int i = OPC_W-1; i >= 0; i--) stream.insert(stream.size(), opc[i]);
      for (int i = ADDR_W-1; i >= 0; i--) stream.insert(stream.size(), addr[i]);
      if (opc == OPC_READ) begin
         // dummy bit, then one clock per data out bit
         repeat (1 + WORD_W) stream.insert(stream.size(), 1'($urandom_range(1)));
      end else if (opc != OPC_EXT || addr[ADDR_W-1 -: 2] == EXT_WRAL ||
                   addr[ADDR_W-1 -: 2] == EXT_ERAL) begin
         for (int i = WORD_W-1; i >= 0; i--) stream.insert(stream.size(), data[i]);
      end

      // raise select to arm the start bit
      send_pins(pin_snapshot(1'b0, 1'b0, 1'($urandom_range(1))));
      send_pins(pin_snapshot(1'b1, 1'b0, 1'($urandom_range(1))));
      foreach (stream[i]) begin
         if (cut < 0 || i < cut) begin
            send_pins(pin_snapshot(1'b1, 1'b0, stream[i]));
            send_pins(pin_snapshot(1'b1, 1'b1, stream[i]));
         end
      end
      // final falling clock, then a select pulse to commit
      send_pins(pin_snapshot(1'b1, 1'b0, 1'($urandom_range(1))));
      send_pins(pin_snapshot(1'b0, 1'b0, 1'($urandom_range(1))));
      send_pins(pin_snapshot(1'b1, 1'b0, 1'($urandom_range(1))));
   endtask

   initial begin
      int               start;
      int               pick;
      int               cut;
      bit               drained;
      logic [OPC_W-1:0]  opc;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] data;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Pin extremes and each pin alone
      send_pins(8'h00);
      send_pins(8'hFF);
      send_pins(8'h00);
      for (int b = 0; b < PIN_W; b++) send_pins(PIN_W'(1) << b);

      // Every command, with writes locked and unlocked
      issue_command(OPC_EXT,   {EXT_WDS, 6'h3F},  16'h0000, -1);
      issue_command(OPC_WRITE, 8'h85,             16'h1234, -1);
      issue_command(OPC_READ,  8'h05,             16'h0000, -1);
      issue_command(OPC_EXT,   {EXT_WEN, 6'h00},  16'h0000, -1);
      issue_command(OPC_WRITE, 8'hFF,             16'h0000, -1);
      issue_command(OPC_READ,  8'h7F,             16'h0000, -1);
      issue_command(OPC_WRITE, 8'h00,             16'h8001, -1);
      issue_command(OPC_READ,  8'h80,             16'h0000, -1);
      issue_command(OPC_EXT,   {EXT_WRAL, 6'h15}, 16'hA5C3, -1);
      issue_command(OPC_READ,  8'h42,             16'h0000, -1);
      issue_command(OPC_ERASE, 8'h42,             16'h0F0F, -1);
      issue_command(OPC_READ,  8'h42,             16'h0000, -1);
      issue_command(OPC_EXT,   {EXT_ERAL, 6'h2A}, 16'h0000, -1);
      issue_command(OPC_READ,  8'h10,             16'h0000, -1);

      // Abort mid-address, leaving a stale bit count for the next command
      issue_command(OPC_WRITE, 8'h33, 16'h5A5A, 6);
      issue_command(OPC_READ,  8'h33, 16'h0000, -1);

      // Clock with select low; the clock is not gated
      repeat (4) begin
         send_pins(pin_snapshot(1'b0, 1'b1, 1'b1));
         send_pins(pin_snapshot(1'b0, 1'b0, 1'b1));
      end

      // Random commands with random content, plus some noise and aborts
      start   = pins_sent;
      drained = 1'b0;
      while (pins_sent - start < RANDOM_ITEMS) begin
         gaps_on = !(pins_sent - start > 150 && pins_sent - start < 300);
         // hold off until every response is back
         if (!drained && pins_sent - start > 350) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (pending != 0);
            drained = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 10) begin
            repeat ($urandom_range(1, 12)) send_pins(PIN_W'($urandom));
         end else begin
            addr = $urandom_range(1) ? addr_pool[$urandom_range(3)] : ADDR_W'($urandom);
            data = WORD_W'($urandom);
            pick = $urandom_range(99);
            if (pick < 15) begin
               opc  = OPC_EXT;
               addr[ADDR_W-1 -: 2] = EXT_WEN;
            end else if (pick < 20) begin
               opc  = OPC_EXT;
               addr[ADDR_W-1 -: 2] = EXT_WDS;
            end else if (pick < 25) begin
               opc  = OPC_EXT;
               addr[ADDR_W-1 -: 2] = EXT_WRAL;
            end else if (pick < 30) begin
               opc  = OPC_EXT;
               addr[ADDR_W-1 -: 2] = EXT_ERAL;
            end else if (pick < 60) begin
               opc = OPC_WRITE;
            end else if (pick < 90) begin
               opc = OPC_READ;
            end else begin
               opc = OPC_ERASE;
            end
            cut = ($urandom_range(99) < 12) ? int'($urandom_range(1, 24)) : -1;
            issue_command(opc, addr, data, cut);
         end
      end
      gaps_on = 1'b1;

      // Drain and report
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (16) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Give up after a generous fixed time
   initial begin
      #3000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
